// ----- hdl/ile_pkg.sv -----
`timescale 1ns / 1ps
package ile_pkg;

  // list geometry
  localparam int MAX_ITEMS = 16;
  localparam int ITEM_BITS = 32;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

  // port field widths
  localparam int MODE_W = 3;
  localparam int POS_W  = 4;
  localparam int WORD_W = 32;
  localparam int FPOS_W = 4;
  localparam int LEN_W  = 5;
  localparam int STAT_W = 2;

  localparam int IN_BITS    = MODE_W + POS_W + WORD_W;
  localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = WORD_W + 1 + FPOS_W + LEN_W + STAT_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [ITEM_BITS-1:0] item_t;
  typedef logic [POS_W-1:0]     pos_t;
  typedef logic [WORD_W-1:0]    word_t;
  typedef logic [FPOS_W-1:0]    fpos_t;
  typedef logic [LEN_W-1:0]     len_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_READ     = 3'd0,
    MODE_WRITE    = 3'd1,
    MODE_INSERT   = 3'd2,
    MODE_APPEND   = 3'd3,
    MODE_DELETE   = 3'd4,
    MODE_DEL_LAST = 3'd5,
    MODE_FIND     = 3'd6,
    MODE_LENGTH   = 3'd7
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;      // capture the incoming item
    logic exec;       // apply a non-scan command and load the result
    logic scan_adv;   // step the find pointer
    logic scan_load;  // load the find result
  } ile_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_find;    // find over a non-empty list
    logic hit;        // entry under the find pointer matches
    logic last;       // find pointer sits on the last entry
  } ile_stat_t;

endpackage

// ----- hdl/ile_dp.sv -----
`timescale 1ns / 1ps
module ile_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ile_pkg::ile_cmd_t    cmd,
  input  ile_pkg::mode_t       in_mode,
  input  ile_pkg::pos_t        in_position,
  input  ile_pkg::word_t       in_item_word,
  output ile_pkg::ile_stat_t   stat,
  output ile_pkg::word_t       item_out_r,
  output logic                 found_r,
  output ile_pkg::fpos_t       found_position_r,
  output ile_pkg::len_t        list_length_r,
  output ile_pkg::status_t     status_r
);

  ile_pkg::item_t   entries_r [ile_pkg::MAX_ITEMS];
  ile_pkg::item_t   prev_w    [ile_pkg::MAX_ITEMS];
  ile_pkg::item_t   next_w    [ile_pkg::MAX_ITEMS];

  ile_pkg::mode_t   mode_r;
  ile_pkg::pos_t    pos_r;
  ile_pkg::item_t   word_r;
  ile_pkg::cnt_t    count_r, count_nxt;
  ile_pkg::idx_t    scan_idx_r;

  ile_pkg::idx_t    rd_idx;
  ile_pkg::item_t   rd_word;
  ile_pkg::item_t   item_c;
  ile_pkg::status_t status_c;
  logic             full, empty, pos_ge, pos_gt;
  logic             do_wr, do_ins, do_app, do_del;

  // command capture
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_r <= in_mode;
      pos_r  <= in_position;
      word_r <= ile_pkg::item_t'(in_item_word);
    end
  end

  // single read port
  always_comb begin
    if (mode_r == ile_pkg::MODE_FIND) begin
      rd_idx = scan_idx_r;
    end else if (mode_r == ile_pkg::MODE_DEL_LAST) begin
      rd_idx = ile_pkg::idx_t'(count_r - ile_pkg::cnt_t'(1));
    end else begin
      rd_idx = ile_pkg::idx_t'(pos_r);
    end
  end
  assign rd_word = entries_r[rd_idx];

  assign full   = (count_r == ile_pkg::cnt_t'(ile_pkg::MAX_ITEMS));
  assign empty  = (count_r == '0);
  assign pos_ge = (int'(pos_r) >= int'(count_r));
  assign pos_gt = (int'(pos_r) >  int'(count_r));

  // check and decode; full/empty checks take precedence over range
  always_comb begin
    item_c    = '0;
    status_c  = ile_pkg::ST_OK;
    count_nxt = count_r;
    do_wr     = 1'b0;
    do_ins    = 1'b0;
    do_app    = 1'b0;
    do_del    = 1'b0;
    unique case (mode_r)
      ile_pkg::MODE_READ: begin
        if (pos_ge) status_c = ile_pkg::ST_RANGE;
        else item_c = rd_word;
      end
      ile_pkg::MODE_WRITE: begin
        if (pos_ge) status_c = ile_pkg::ST_RANGE;
        else do_wr = cmd.exec;
      end
      ile_pkg::MODE_INSERT: begin
        if (full) status_c = ile_pkg::ST_FULL;
        else if (pos_gt) status_c = ile_pkg::ST_RANGE;
        else begin
          do_ins    = cmd.exec;
          count_nxt = count_r + ile_pkg::cnt_t'(1);
        end
      end
      ile_pkg::MODE_APPEND: begin
        if (full) status_c = ile_pkg::ST_FULL;
        else begin
          do_app    = cmd.exec;
          count_nxt = count_r + ile_pkg::cnt_t'(1);
        end
      end
      ile_pkg::MODE_DELETE: begin
        if (empty) status_c = ile_pkg::ST_EMPTY;
        else if (pos_ge) status_c = ile_pkg::ST_RANGE;
        else begin
          item_c    = rd_word;
          do_del    = cmd.exec;
          count_nxt = count_r - ile_pkg::cnt_t'(1);
        end
      end
      ile_pkg::MODE_DEL_LAST: begin
        if (empty) status_c = ile_pkg::ST_EMPTY;
        else begin
          item_c    = rd_word;
          count_nxt = count_r - ile_pkg::cnt_t'(1);
        end
      end
      ile_pkg::MODE_FIND, ile_pkg::MODE_LENGTH: begin
      end
      default: begin
      end
    endcase
  end

  // entry row: each entry loads the word, its lower or its upper neighbor
  for (genvar i = 0; i < ile_pkg::MAX_ITEMS; i++) begin : g_entry
    if (i > 0) begin : g_prev
      assign prev_w[i] = entries_r[i-1];
    end else begin : g_prev0
      assign prev_w[i] = '0;
    end
    if (i < ile_pkg::MAX_ITEMS - 1) begin : g_next
      assign next_w[i] = entries_r[i+1];
    end else begin : g_next0
      assign next_w[i] = '0;
    end

    always_ff @(posedge clk) begin
      if (((do_wr || do_ins) && int'(pos_r) == i) || (do_app && int'(count_r) == i)) begin
        entries_r[i] <= word_r;
      end else if (do_ins && i > int'(pos_r) && i <= int'(count_r)) begin
        entries_r[i] <= prev_w[i];
      end else if (do_del && i >= int'(pos_r) && i + 1 < int'(count_r)) begin
        entries_r[i] <= next_w[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      scan_idx_r <= '0;
    end else if (cmd.scan_adv) begin
      scan_idx_r <= scan_idx_r + ile_pkg::idx_t'(1);
    end
  end

  assign stat.is_find = (mode_r == ile_pkg::MODE_FIND) && !empty;
  assign stat.hit     = (rd_word == word_r);
  assign stat.last    = (int'(scan_idx_r) + 1 >= int'(count_r));

  // result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      item_out_r       <= ile_pkg::word_t'(item_c);
      found_r          <= 1'b0;
      found_position_r <= '0;
      list_length_r    <= ile_pkg::len_t'(count_nxt);
      status_r         <= status_c;
    end else if (cmd.scan_load) begin
      item_out_r       <= '0;
      found_r          <= stat.hit;
      found_position_r <= stat.hit ? ile_pkg::fpos_t'(scan_idx_r) : '0;
      list_length_r    <= ile_pkg::len_t'(count_r);
      status_r         <= ile_pkg::ST_OK;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) <= ile_pkg::MAX_ITEMS)
    else $error("entry count above capacity");

  a_fail_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && status_c != ile_pkg::ST_OK) |=> $stable(count_r))
    else $error("failed command changed the count");

endmodule

// ----- hdl/ile_ctrl.sv -----
`timescale 1ns / 1ps
module ile_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid_r,
  input  logic                out_tready,
  input  ile_pkg::ile_stat_t  stat,
  output ile_pkg::ile_cmd_t   cmd
);

  ile_pkg::state_t state_r, state_nxt;
  logic            out_free;
  logic            out_tvalid_nxt;
  logic            scan_done;

  assign out_free  = !out_tvalid_r || out_tready;
  assign scan_done = stat.hit || stat.last;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ile_pkg::S_IDLE: if (in_tvalid) state_nxt = ile_pkg::S_EXEC;
      ile_pkg::S_EXEC: begin
        if (stat.is_find) state_nxt = ile_pkg::S_SCAN;
        else if (out_free) state_nxt = ile_pkg::S_IDLE;
      end
      ile_pkg::S_SCAN: if (scan_done && out_free) state_nxt = ile_pkg::S_IDLE;
      default: state_nxt = ile_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_tready     = 1'b0;
    cmd           = '0;
    unique case (state_r)
      ile_pkg::S_IDLE: begin
        in_tready = 1'b1;
        cmd.latch = in_tvalid;
      end
      ile_pkg::S_EXEC: cmd.exec = !stat.is_find && out_free;
      ile_pkg::S_SCAN: begin
        cmd.scan_load = scan_done && out_free;
        cmd.scan_adv  = !scan_done;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (cmd.exec || cmd.scan_load) out_tvalid_nxt = 1'b1;
    else if (out_tready) out_tvalid_nxt = 1'b0;
    else out_tvalid_nxt = out_tvalid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ile_pkg::S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec || cmd.scan_load) |-> out_free)
    else $error("result loaded over a pending result");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> state_r == ile_pkg::S_EXEC)
    else $error("accepted item not executed");

  a_no_step_past_end: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_adv |-> !stat.last)
    else $error("find pointer stepped past last entry");

  a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.latch, cmd.exec, cmd.scan_adv, cmd.scan_load}))
    else $error("conflicting datapath commands");

endmodule

// ----- hdl/indexed_list_engine.sv -----
`timescale 1ns / 1ps
// Indexed list engine: an ordered list of up to 16 32-bit item words. Each
// input item is a command (read, write, insert at, append, delete at, delete
// last, find, length) and yields exactly one result item carrying the read or
// removed word, the find outcome, the list length after the command and a
// status (ok, index out of range, list full, list empty). A failing command
// leaves the list untouched. One command is processed at a time: an item is
// taken in the idle state and executed in the exec state once the output
// register is free; find walks the entries one per cycle through the single
// read port and stops at the first match or the last entry.
// Inserts and deletes shift the entry row at once. A new command is taken
// while the previous result still waits on the output register; it stalls only
// if its own result is ready before that one has gone. Entries hold no reset
// value; only entries below the current length are ever read.
module indexed_list_engine (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [2:0] mode, [6:3] position, [38:7] item_word, [39] zero
  input  logic [ile_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [31:0] item_out, [32] found, [36:33] found_position,
  // [41:37] list_length, [43:42] status, [47:44] zero
  output logic [ile_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int PosLo  = ile_pkg::MODE_W;
  localparam int WordLo = ile_pkg::MODE_W + ile_pkg::POS_W;
  localparam int OutPad = ile_pkg::OUT_DATA_W - ile_pkg::OUT_BITS;

  ile_pkg::ile_cmd_t  cmd;
  ile_pkg::ile_stat_t stat;
  ile_pkg::mode_t     in_mode;
  ile_pkg::pos_t      in_position;
  ile_pkg::word_t     in_item_word;
  ile_pkg::word_t     item_out_r;
  logic               found_r;
  ile_pkg::fpos_t     found_position_r;
  ile_pkg::len_t      list_length_r;
  ile_pkg::status_t   status_r;
  logic               unused_pad;

  // unpack the command item
  assign in_mode      = ile_pkg::mode_t'(in_tdata[ile_pkg::MODE_W-1:0]);
  assign in_position  = in_tdata[WordLo-1:PosLo];
  assign in_item_word = in_tdata[ile_pkg::IN_BITS-1:WordLo];
  assign unused_pad   = ^in_tdata[ile_pkg::IN_DATA_W-1:ile_pkg::IN_BITS];

  ile_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .out_tvalid_r (out_tvalid),
    .out_tready   (out_tready),
    .stat         (stat),
    .cmd          (cmd)
  );

  ile_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_mode          (in_mode),
    .in_position      (in_position),
    .in_item_word     (in_item_word),
    .stat             (stat),
    .item_out_r       (item_out_r),
    .found_r          (found_r),
    .found_position_r (found_position_r),
    .list_length_r    (list_length_r),
    .status_r         (status_r)
  );

  // pack the result item, first field lowest; pad bits carry zero
  assign out_tdata = {{OutPad{unused_pad & 1'b0}}, status_r, list_length_r,
                      found_position_r, found_r, item_out_r};

endmodule

// ----- tb/tb_indexed_list_engine.sv -----
`timescale 1ns / 1ps
module tb_indexed_list_engine;

  // one command as queued for the driver
  typedef struct {
    ile_pkg::mode_t mode;
    ile_pkg::pos_t  pos;
    ile_pkg::word_t word;
    int             gap;   // idle cycles after this item is taken
  } list_cmd_t;

  // one result as expected on the output
  typedef struct {
    ile_pkg::word_t   item;
    logic             found;
    ile_pkg::fpos_t   fpos;
    ile_pkg::len_t    len;
    ile_pkg::status_t status;
  } list_result_t;

  typedef enum int {
    GEN_GROW,
    GEN_SHRINK,
    GEN_MIXED
  } gen_phase_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  // [2:0] mode, [6:3] position, [38:7] item_word, [39] zero
  logic [ile_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  // [31:0] item_out, [32] found, [36:33] found_position,
  // [41:37] list_length, [43:42] status, [47:44] zero
  logic [ile_pkg::OUT_DATA_W-1:0] out_tdata;

  indexed_list_engine uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial forever #4 clk = ~clk;

  list_cmd_t    pending_cmds[$];
  list_result_t expected_results[$];
  int           mismatches = 0;

  // predictor copy of the list
  ile_pkg::word_t list_words[ile_pkg::MAX_ITEMS];
  int             list_len = 0;

  // length tracked while generating, used to aim positions in range
  int gen_len = 0;

  // driver / receiver bookkeeping
  int   send_gap = 0;
  int   rx_wait = 0;
  int   rx_count = 0;
  int   rx_draw;
  logic long_hold_done = 1'b0;

  // Applies one command to the predictor list and returns its result.
  // Full is checked before the index on inserts, empty before the index
  // on deletes; failing commands leave the list alone.
  function automatic list_result_t run_list_command(ile_pkg::mode_t mode,
                                                    ile_pkg::pos_t pos,
                                                    ile_pkg::word_t word);
    list_result_t r;
    int i;
    r.item   = '0;
    r.found  = 1'b0;
    r.fpos   = '0;
    r.status = ile_pkg::ST_OK;
    case (mode)
      ile_pkg::MODE_READ: begin
        if (pos >= list_len) r.status = ile_pkg::ST_RANGE;
        else r.item = list_words[pos];
      end
      ile_pkg::MODE_WRITE: begin
        if (pos >= list_len) r.status = ile_pkg::ST_RANGE;
        else list_words[pos] = word;
      end
      ile_pkg::MODE_INSERT: begin
        if (list_len >= ile_pkg::MAX_ITEMS) r.status = ile_pkg::ST_FULL;
        else if (pos > list_len) r.status = ile_pkg::ST_RANGE;
        else begin
          for (i = list_len; i > pos; i--) list_words[i] = list_words[i-1];
          list_words[pos] = word;
          list_len++;
        end
      end
      ile_pkg::MODE_APPEND: begin
        if (list_len >= ile_pkg::MAX_ITEMS) r.status = ile_pkg::ST_FULL;
        else begin
          list_words[list_len] = word;
          list_len++;
        end
      end
      ile_pkg::MODE_DELETE: begin
        if (list_len == 0) r.status = ile_pkg::ST_EMPTY;
        else if (pos >= list_len) r.status = ile_pkg::ST_RANGE;
        else begin
          r.item = list_words[pos];
          for (i = pos; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
        end
      end
      ile_pkg::MODE_DEL_LAST: begin
        if (list_len == 0) r.status = ile_pkg::ST_EMPTY;
        else begin
          list_len--;
          r.item = list_words[list_len];
        end
      end
      ile_pkg::MODE_FIND: begin
        for (i = 0; i < list_len; i++) begin
          if (list_words[i] == word) begin
            r.found = 1'b1;
            r.fpos  = ile_pkg::fpos_t'(i);
            break;
          end
        end
      end
      default: ;
    endcase
    r.len = ile_pkg::len_t'(list_len);
    return r;
  endfunction

  // queue a command and follow the list length it leaves behind
  task automatic add_cmd(ile_pkg::mode_t mode, ile_pkg::pos_t pos, ile_pkg::word_t word,
                         int gap);
    list_cmd_t c;
    c.mode = mode;
    c.pos  = pos;
    c.word = word;
    c.gap  = gap;
    pending_cmds.push_back(c);
    case (mode)
      ile_pkg::MODE_INSERT:   if (gen_len < ile_pkg::MAX_ITEMS && pos <= gen_len) gen_len++;
      ile_pkg::MODE_APPEND:   if (gen_len < ile_pkg::MAX_ITEMS) gen_len++;
      ile_pkg::MODE_DELETE:   if (gen_len > 0 && pos < gen_len) gen_len--;
      ile_pkg::MODE_DEL_LAST: if (gen_len > 0) gen_len--;
      default: ;
    endcase
  endtask

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %h, got %h", field, want, got);
    end
  endtask

  // Driver: holds an item until taken, then idles for its gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      send_gap  <= 0;
    end else if (!(in_tvalid && !in_tready)) begin
      if (send_gap > 0) begin
        in_tvalid <= 1'b0;
        send_gap  <= send_gap - 1;
      end else if (pending_cmds.size() > 0) begin
        in_tdata  <= {1'b0, pending_cmds[0].word, pending_cmds[0].pos, pending_cmds[0].mode};
        send_gap  <= pending_cmds[0].gap;
        in_tvalid <= 1'b1;
        void'(pending_cmds.pop_front());
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stall after each result, a quiet stretch every so
  // often, and one long hold-off so the block backs up onto its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_wait    <= 0;
    end else if (out_tvalid && out_tready) begin
      rx_count <= rx_count + 1;
      if (!long_hold_done && rx_count == 300) begin
        long_hold_done <= 1'b1;
        rx_wait        <= 400;
        out_tready     <= 1'b0;
      end else begin
        rx_draw = ((rx_count / 80) % 4 == 1) ? 0 : $urandom_range(0, 15);
        rx_wait    <= rx_draw;
        out_tready <= (rx_draw == 0);
      end
    end else if (rx_wait > 0) begin
      rx_wait    <= rx_wait - 1;
      out_tready <= (rx_wait == 1);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Monitor: predict on every taken command first, then check results.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        expected_results.push_back(run_list_command(ile_pkg::mode_t'(in_tdata[2:0]),
                                                    ile_pkg::pos_t'(in_tdata[6:3]),
                                                    ile_pkg::word_t'(in_tdata[38:7])));
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", out_tdata);
        end else begin
          check_field("item_out", 32'(expected_results[0].item), 32'(out_tdata[31:0]));
          check_field("found", 32'(expected_results[0].found), 32'(out_tdata[32]));
          check_field("found_position", 32'(expected_results[0].fpos),
                      32'(out_tdata[36:33]));
          check_field("list_length", 32'(expected_results[0].len), 32'(out_tdata[41:37]));
          check_field("status", 32'(expected_results[0].status), 32'(out_tdata[43:42]));
          void'(expected_results.pop_front());
        end
      end
    end
  end

  // values reused so finds hit and duplicates appear
  ile_pkg::word_t word_pool[6] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                                   32'h8000_0000, 32'h1234_5678, 32'hA5A5_A5A5};

  // per-phase weights, in mode order read..length
  int mode_weights[3][8] = '{'{10, 10, 30, 25, 5, 5, 10, 5},
                             '{10, 10, 5, 5, 30, 20, 15, 5},
                             '{13, 13, 12, 12, 13, 12, 13, 12}};

  initial begin
    gen_phase_t     phase;
    int             mixed_left;
    int             n;
    int             r;
    int             m;
    ile_pkg::mode_t mode;
    ile_pkg::pos_t  pos;
    ile_pkg::word_t word;
    int             gap;

    // directed: empty list errors, fill to full, full errors, ends of the list
    add_cmd(ile_pkg::MODE_READ, 4'd0, 32'h0, 0);
    add_cmd(ile_pkg::MODE_WRITE, 4'd0, 32'hDEAD_BEEF, 0);
    add_cmd(ile_pkg::MODE_INSERT, 4'd1, 32'h1, 3);
    add_cmd(ile_pkg::MODE_DELETE, 4'd15, 32'h0, 0);      // empty wins over range
    add_cmd(ile_pkg::MODE_DEL_LAST, 4'd0, 32'h0, 0);
    add_cmd(ile_pkg::MODE_FIND, 4'd0, 32'h0, 1);          // nothing to find
    add_cmd(ile_pkg::MODE_INSERT, 4'd0, 32'hFFFF_FFFF, 0);
    for (n = 0; n < ile_pkg::MAX_ITEMS - 1; n++)
      add_cmd(ile_pkg::MODE_APPEND, ile_pkg::pos_t'(n),
              ile_pkg::word_t'((n % 3 == 0) ? 32'h0 : 32'h100 + n), 0);
    add_cmd(ile_pkg::MODE_APPEND, 4'd0, 32'h5555_5555, 0);   // full
    add_cmd(ile_pkg::MODE_INSERT, 4'd15, 32'h5555_5555, 2);  // full, index in range
    add_cmd(ile_pkg::MODE_READ, 4'd15, 32'h0, 0);
    add_cmd(ile_pkg::MODE_DELETE, 4'd0, 32'h0, 0);
    add_cmd(ile_pkg::MODE_FIND, 4'd0, 32'h0, 0);             // first of duplicates
    add_cmd(ile_pkg::MODE_LENGTH, 4'd9, 32'h7, 0);
    add_cmd(ile_pkg::MODE_INSERT, 4'd15, 32'hFFFF_FFFF, 0);  // insert at the end index
    add_cmd(ile_pkg::MODE_WRITE, 4'd15, 32'h8000_0000, 0);

    // random: grow to full, shrink to empty, mixed, over and over
    phase = GEN_GROW;
    mixed_left = 0;
    for (n = 0; n < 900; n++) begin
      r = $urandom_range(0, 99);
      m = 0;
      while (r >= mode_weights[phase][m]) begin
        r -= mode_weights[phase][m];
        m++;
      end
      mode = ile_pkg::mode_t'(m);

      if ($urandom_range(0, 7) == 0) pos = ile_pkg::pos_t'($urandom_range(0, 15));
      else if (mode == ile_pkg::MODE_INSERT && gen_len < ile_pkg::MAX_ITEMS)
        pos = ile_pkg::pos_t'($urandom_range(0, gen_len));
      else if ((mode == ile_pkg::MODE_READ || mode == ile_pkg::MODE_WRITE ||
                mode == ile_pkg::MODE_DELETE) && gen_len > 0)
        pos = ile_pkg::pos_t'($urandom_range(0, gen_len - 1));
      else pos = ile_pkg::pos_t'($urandom_range(0, 15));

      word = ($urandom_range(0, 3) != 0) ? word_pool[$urandom_range(0, 5)] : $urandom();
      gap  = ((n / 60) % 4 == 3) ? 0 : $urandom_range(0, 15);
      add_cmd(mode, pos, word, gap);

      case (phase)
        GEN_GROW:   if (gen_len == ile_pkg::MAX_ITEMS) phase = GEN_SHRINK;
        GEN_SHRINK: if (gen_len == 0) begin
          phase = GEN_MIXED;
          mixed_left = 40;
        end
        default: begin
          mixed_left--;
          if (mixed_left == 0) phase = GEN_GROW;
        end
      endcase
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    if (mismatches == 0 && expected_results.size() == 0)
      $display("indexed_list_engine test passed");
    else
      $display("indexed_list_engine test failed");
    $finish;
  end

  // hang guard, far above the slowest legal run
  initial begin
    #4000000;
    $display("indexed_list_engine test failed");
    $finish;
  end

endmodule
